### rtl/core/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg - ready queue scheduler types
// Item layouts, queue entry layout, policy, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rqs_pkg;

    typedef enum logic [2:0] {
        POL_FIFO = 3'd0,
        POL_SJF  = 3'd1,
        POL_SRTF = 3'd2,
        POL_RR   = 3'd3,
        POL_PRIO = 3'd4
    } policy_t;

    localparam logic CMD_ENQ   = 1'b0;
    localparam logic CMD_SCHED = 1'b1;

    typedef enum logic [1:0] {
        STAT_ENQUEUED   = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_DISPATCHED = 2'd2,
        STAT_IDLE       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_MOVE,
        ST_MOVE_END,
        ST_INSERT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  proc_id;
        logic [15:0] job_length;
        logic [7:0]  proc_priority;
        logic        cur_continues;
        logic [15:0] cur_remaining;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] next_id;
        logic       preempted;
        logic [4:0] ready_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] len;
        logic [7:0]  pri;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### rtl/core/rqs_ram.sv
// ----------------------------------------------------------------------------
// rqs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/ready_queue_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// ready_queue_cpu_scheduler - ready queue with FIFO/SJF/SRTF/RR/priority
// Ordered ready queue in RAM, one running entry, sequenced scan and shift.
// ----------------------------------------------------------------------------
//  channel  | ports                         | carries
//  ---------+-------------------------------+-------------------------------
//  input    | s_valid s_ready s_item        | enqueue or schedule command
//  result   | m_valid m_ready m_item        | status, next id, preempt, count
//  config   | cfg_valid cfg_ready cfg_wdata | scheduling policy
//
//  Enqueue and trivial schedule items go from idle straight to the result
//  stage. A schedule item that searches the queue reads each scanned entry,
//  then, where needed, shifts entries one at a time, finishes the shift and
//  re-inserts the running entry: the single RAM read port sets this order.
//  Reset clears count, running entry and policy; queue RAM is not cleared.
//  A stalled result waits in the output register; the next item is taken
//  meanwhile and held before its own result stage until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_cpu_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rqs_pkg::in_item_t    s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rqs_pkg::out_item_t        m_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_wdata
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rqs_pkg::state_t    state_reg, state_next;
    logic [2:0]         policy_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               run_valid_reg, run_valid_next;
    logic [7:0]         run_id_reg, run_id_next;
    logic [7:0]         run_pri_reg, run_pri_next;
    logic [15:0]        crem_reg, crem_next;
    logic               kept_reg, kept_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;
    logic [AW-1:0]      scan_last_reg, scan_last_next;
    logic               sc_pend_reg;
    logic [AW-1:0]      sc_idx_reg, sc_idx_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    rqs_pkg::entry_t    best_reg, best_next;
    logic [AW-1:0]      mv_src_reg, mv_src_next;
    logic [AW-1:0]      mv_last_reg, mv_last_next;
    logic               mv_down_reg, mv_down_next;
    logic               mv_pend_reg;
    logic [AW-1:0]      mv_dst_reg, mv_dst_next;
    logic               ins_reg, ins_next;
    logic [AW-1:0]      ins_addr_reg, ins_addr_next;
    rqs_pkg::entry_t    ins_data_reg, ins_data_next;
    rqs_pkg::status_t   res_status_reg, res_status_next;
    logic [7:0]         res_id_reg, res_id_next;
    logic               res_pre_reg, res_pre_next;
    logic               m_valid_reg, m_valid_next;
    rqs_pkg::out_item_t m_item_reg, m_item_next;

    rqs_pkg::policy_t   pol;
    logic               min_mode, pri_mode;
    logic [AW-1:0]      cnt_m1;
    logic [15:0]        cmp_a, cmp_b;
    logic               cmp_gt;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    rqs_pkg::entry_t              ram_wdata, ram_rdata;
    logic [rqs_pkg::ENTRY_W-1:0]  ram_rdata_raw;

    rqs_ram #(
        .WIDTH (rqs_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    assign ram_rdata = rqs_pkg::entry_t'(ram_rdata_raw);

    // unused codes behave as FIFO
    assign pol      = (policy_reg > 3'(rqs_pkg::POL_PRIO)) ? rqs_pkg::POL_FIFO
                                                           : rqs_pkg::policy_t'(policy_reg);
    assign min_mode = (pol == rqs_pkg::POL_SJF) || (pol == rqs_pkg::POL_SRTF);
    assign pri_mode = (pol == rqs_pkg::POL_PRIO);
    assign cnt_m1   = AW'(count_reg - CW'(1));

    // shared comparator: scan step, then the SRTF preemption test
    always_comb begin
        if (state_reg == rqs_pkg::ST_DECIDE) begin
            cmp_a = crem_reg;
            cmp_b = best_reg.len;
        end else if (pri_mode) begin
            cmp_a = {8'd0, ram_rdata.pri};
            cmp_b = {8'd0, best_reg.pri};
        end else begin
            cmp_a = best_reg.len;
            cmp_b = ram_rdata.len;
        end
    end
    assign cmp_gt = cmp_a > cmp_b;

    assign s_ready   = (state_reg == rqs_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rqs_pkg::ST_IDLE;
            policy_reg    <= 3'(rqs_pkg::POL_FIFO);
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_pri_reg   <= '0;
            sc_pend_reg   <= 1'b0;
            mv_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid) begin
                policy_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_pri_reg   <= run_pri_next;
            sc_pend_reg   <= (state_reg == rqs_pkg::ST_SCAN);
            mv_pend_reg   <= (state_reg == rqs_pkg::ST_MOVE);
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crem_reg       <= crem_next;
        kept_reg       <= kept_next;
        scan_idx_reg   <= scan_idx_next;
        scan_last_reg  <= scan_last_next;
        sc_idx_reg     <= sc_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        mv_src_reg     <= mv_src_next;
        mv_last_reg    <= mv_last_next;
        mv_down_reg    <= mv_down_next;
        mv_dst_reg     <= mv_dst_next;
        ins_reg        <= ins_next;
        ins_addr_reg   <= ins_addr_next;
        ins_data_reg   <= ins_data_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_pre_reg    <= res_pre_next;
        m_item_reg     <= m_item_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        run_pri_next    = run_pri_reg;
        crem_next       = crem_reg;
        kept_next       = kept_reg;
        scan_idx_next   = scan_idx_reg;
        scan_last_next  = scan_last_reg;
        sc_idx_next     = sc_idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        mv_src_next     = mv_src_reg;
        mv_last_next    = mv_last_reg;
        mv_down_next    = mv_down_reg;
        mv_dst_next     = mv_dst_reg;
        ins_next        = ins_reg;
        ins_addr_next   = ins_addr_reg;
        ins_data_next   = ins_data_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_pre_next    = res_pre_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // scan data arrives in the cycle after its read; oldest wins ties
        if (sc_pend_reg) begin
            if (sc_idx_reg == '0 || ((min_mode || pri_mode) && cmp_gt)) begin
                best_next     = ram_rdata;
                best_idx_next = sc_idx_reg;
            end
        end

        // shift engine write-back
        if (mv_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = mv_dst_reg;
            ram_wdata = ram_rdata;
        end

        case (state_reg)
            rqs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    crem_next    = s_item.cur_remaining;
                    res_pre_next = 1'b0;
                    res_id_next  = '0;
                    kept_next    = run_valid_reg && s_item.cur_continues;
                    ins_next     = 1'b0;
                    if (s_item.cmd == rqs_pkg::CMD_ENQ) begin
                        if (count_reg < CW'(QUEUE_DEPTH)) begin
                            ram_we          = 1'b1;
                            ram_waddr       = AW'(count_reg);
                            ram_wdata.id    = s_item.proc_id;
                            ram_wdata.len   = s_item.job_length;
                            ram_wdata.pri   = s_item.proc_priority;
                            count_next      = count_reg + CW'(1);
                            res_status_next = rqs_pkg::STAT_ENQUEUED;
                        end else begin
                            res_status_next = rqs_pkg::STAT_FULL;
                        end
                        state_next = rqs_pkg::ST_OUT;
                    end else if (run_valid_reg && s_item.cur_continues) begin
                        if ((pol == rqs_pkg::POL_SRTF || pol == rqs_pkg::POL_RR)
                            && count_reg != '0) begin
                            scan_idx_next  = '0;
                            scan_last_next = (pol == rqs_pkg::POL_SRTF) ? cnt_m1 : '0;
                            state_next     = rqs_pkg::ST_SCAN;
                        end else begin
                            res_status_next = rqs_pkg::STAT_DISPATCHED;
                            res_id_next     = run_id_reg;
                            state_next      = rqs_pkg::ST_OUT;
                        end
                    end else if (count_reg == '0) begin
                        run_valid_next  = 1'b0;
                        res_status_next = rqs_pkg::STAT_IDLE;
                        state_next      = rqs_pkg::ST_OUT;
                    end else begin
                        scan_idx_next  = '0;
                        scan_last_next = (min_mode || pri_mode) ? cnt_m1 : '0;
                        state_next     = rqs_pkg::ST_SCAN;
                    end
                end
            end

            rqs_pkg::ST_SCAN: begin
                ram_raddr   = scan_idx_reg;
                sc_idx_next = scan_idx_reg;
                if (scan_idx_reg == scan_last_reg) begin
                    state_next = rqs_pkg::ST_SCAN_END;
                end else begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end

            rqs_pkg::ST_SCAN_END: begin
                state_next = rqs_pkg::ST_DECIDE;
            end

            rqs_pkg::ST_DECIDE: begin
                res_status_next = rqs_pkg::STAT_DISPATCHED;
                if (kept_reg && pol == rqs_pkg::POL_SRTF) begin
                    if (cmp_gt) begin
                        // chosen entry leaves, running one goes in at the head
                        res_pre_next      = 1'b1;
                        res_id_next       = best_reg.id;
                        run_id_next       = best_reg.id;
                        run_pri_next      = best_reg.pri;
                        ins_next          = 1'b1;
                        ins_addr_next     = '0;
                        ins_data_next.id  = run_id_reg;
                        ins_data_next.len = crem_reg;
                        ins_data_next.pri = run_pri_reg;
                        if (best_idx_reg != '0) begin
                            mv_src_next  = best_idx_reg - AW'(1);
                            mv_last_next = '0;
                            mv_down_next = 1'b1;
                            state_next   = rqs_pkg::ST_MOVE;
                        end else begin
                            state_next = rqs_pkg::ST_INSERT;
                        end
                    end else begin
                        res_id_next = run_id_reg;
                        state_next  = rqs_pkg::ST_OUT;
                    end
                end else if (kept_reg) begin
                    // round robin: head runs, running one goes to the tail
                    res_pre_next      = 1'b1;
                    res_id_next       = best_reg.id;
                    run_id_next       = best_reg.id;
                    run_pri_next      = best_reg.pri;
                    ins_next          = 1'b1;
                    ins_addr_next     = cnt_m1;
                    ins_data_next.id  = run_id_reg;
                    ins_data_next.len = crem_reg;
                    ins_data_next.pri = run_pri_reg;
                    if (cnt_m1 != '0) begin
                        mv_src_next  = AW'(1);
                        mv_last_next = cnt_m1;
                        mv_down_next = 1'b0;
                        state_next   = rqs_pkg::ST_MOVE;
                    end else begin
                        state_next = rqs_pkg::ST_INSERT;
                    end
                end else begin
                    res_id_next    = best_reg.id;
                    run_id_next    = best_reg.id;
                    run_pri_next   = best_reg.pri;
                    run_valid_next = 1'b1;
                    count_next     = count_reg - CW'(1);
                    if (best_idx_reg != cnt_m1) begin
                        mv_src_next  = best_idx_reg + AW'(1);
                        mv_last_next = cnt_m1;
                        mv_down_next = 1'b0;
                        state_next   = rqs_pkg::ST_MOVE;
                    end else begin
                        state_next = rqs_pkg::ST_OUT;
                    end
                end
            end

            rqs_pkg::ST_MOVE: begin
                ram_raddr   = mv_src_reg;
                mv_dst_next = mv_down_reg ? mv_src_reg + AW'(1) : mv_src_reg - AW'(1);
                if (mv_src_reg == mv_last_reg) begin
                    state_next = rqs_pkg::ST_MOVE_END;
                end else begin
                    mv_src_next = mv_down_reg ? mv_src_reg - AW'(1) : mv_src_reg + AW'(1);
                end
            end

            rqs_pkg::ST_MOVE_END: begin
                state_next = ins_reg ? rqs_pkg::ST_INSERT : rqs_pkg::ST_OUT;
            end

            rqs_pkg::ST_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = ins_addr_reg;
                ram_wdata  = ins_data_reg;
                state_next = rqs_pkg::ST_OUT;
            end

            rqs_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_item_next.status      = res_status_reg;
                    m_item_next.next_id     = res_id_reg;
                    m_item_next.preempted   = res_pre_reg;
                    m_item_next.ready_count = 5'(count_reg);
                    state_next              = rqs_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rqs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### test/tb_ready_queue_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// tb_ready_queue_cpu_scheduler - testbench for the ready queue scheduler
// Sends enqueue and schedule items under every policy, keeps its own copy
// of the ready queue and running entry, and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ready_queue_cpu_scheduler;

    localparam int QDEPTH = 16;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    rqs_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    rqs_pkg::out_item_t m_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_wdata;

    // scheduler state as the testbench sees it
    logic [7:0]  q_id  [QDEPTH];
    logic [15:0] q_len [QDEPTH];
    logic [7:0]  q_pri [QDEPTH];
    int          q_count     = 0;
    logic        running     = 1'b0;
    logic [7:0]  running_id  = '0;
    logic [7:0]  running_pri = '0;
    logic [2:0]  cur_policy  = 3'(rqs_pkg::POL_FIFO);

    rqs_pkg::out_item_t outcome_q [$];
    int                 mismatches = 0;
    bit                 quiet      = 1'b0;

    ready_queue_cpu_scheduler #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // queue model
    // ------------------------------------------------------------------
    function automatic void drop_entry(input int k);
        int i;
        for (i = k; i + 1 < q_count; i++) begin
            q_id[i]  = q_id[i + 1];
            q_len[i] = q_len[i + 1];
            q_pri[i] = q_pri[i + 1];
        end
        q_count--;
    endfunction

    function automatic void append_entry(input logic [7:0] id, input logic [15:0] len,
                                         input logic [7:0] pri);
        q_id[q_count]  = id;
        q_len[q_count] = len;
        q_pri[q_count] = pri;
        q_count++;
    endfunction

    // ties go to the entry nearest the head
    function automatic int shortest_entry();
        int best;
        int i;
        best = 0;
        for (i = 1; i < q_count; i++)
            if (q_len[i] < q_len[best]) best = i;
        return best;
    endfunction

    function automatic rqs_pkg::out_item_t scheduler_outcome(input rqs_pkg::in_item_t it);
        rqs_pkg::out_item_t r;
        logic [2:0]         pol;
        logic [7:0]         nid;
        logic [7:0]         npri;
        int                 k;
        int                 i;
        r = '0;
        // codes above priority fall back to FIFO
        pol = (cur_policy > 3'(rqs_pkg::POL_PRIO)) ? 3'(rqs_pkg::POL_FIFO) : cur_policy;
        if (it.cmd == rqs_pkg::CMD_ENQ) begin
            if (q_count < QDEPTH) begin
                append_entry(it.proc_id, it.job_length, it.proc_priority);
                r.status = rqs_pkg::STAT_ENQUEUED;
            end else begin
                r.status = rqs_pkg::STAT_FULL;
            end
        end else if (running && it.cur_continues) begin
            r.status  = rqs_pkg::STAT_DISPATCHED;
            r.next_id = running_id;
            if (pol == rqs_pkg::POL_SRTF && q_count > 0) begin
                k = shortest_entry();
                if (q_len[k] < it.cur_remaining) begin
                    nid  = q_id[k];
                    npri = q_pri[k];
                    drop_entry(k);
                    // preempted entry goes back at the head
                    for (i = q_count; i > 0; i--) begin
                        q_id[i]  = q_id[i - 1];
                        q_len[i] = q_len[i - 1];
                        q_pri[i] = q_pri[i - 1];
                    end
                    q_id[0]  = running_id;
                    q_len[0] = it.cur_remaining;
                    q_pri[0] = running_pri;
                    q_count++;
                    running_id  = nid;
                    running_pri = npri;
                    r.next_id   = nid;
                    r.preempted = 1'b1;
                end
            end else if (pol == rqs_pkg::POL_RR && q_count > 0) begin
                nid  = q_id[0];
                npri = q_pri[0];
                drop_entry(0);
                append_entry(running_id, it.cur_remaining, running_pri);
                running_id  = nid;
                running_pri = npri;
                r.next_id   = nid;
                r.preempted = 1'b1;
            end
        end else if (q_count == 0) begin
            running  = 1'b0;
            r.status = rqs_pkg::STAT_IDLE;
        end else begin
            k = 0;
            if (pol == rqs_pkg::POL_SJF || pol == rqs_pkg::POL_SRTF) begin
                k = shortest_entry();
            end else if (pol == rqs_pkg::POL_PRIO) begin
                for (i = 1; i < q_count; i++)
                    if (q_pri[i] > q_pri[k]) k = i;
            end
            running_id  = q_id[k];
            running_pri = q_pri[k];
            running     = 1'b1;
            drop_entry(k);
            r.status  = rqs_pkg::STAT_DISPATCHED;
            r.next_id = running_id;
        end
        r.ready_count = 5'(q_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin : check_results
        rqs_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: status %0d id %0d pre %0d cnt %0d",
                             $realtime, m_item.status, m_item.next_id, m_item.preempted,
                             m_item.ready_count);
            end else begin
                want = outcome_q.pop_front();
                if (m_item.status !== want.status || m_item.next_id !== want.next_id ||
                    m_item.preempted !== want.preempted ||
                    m_item.ready_count !== want.ready_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch: expected status %0d id %0d pre %0d cnt %0d,",
                                  " got status %0d id %0d pre %0d cnt %0d"},
                                 $realtime, want.status, want.next_id, want.preempted,
                                 want.ready_count, m_item.status, m_item.next_id,
                                 m_item.preempted, m_item.ready_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // valid is left high after acceptance; the next call replaces the item or lowers it, settle lowers it
    task automatic send_item(input rqs_pkg::in_item_t it);
        while (!quiet && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        outcome_q.push_back(scheduler_outcome(it));
    endtask

    task automatic enqueue(input logic [7:0] id, input logic [15:0] len, input logic [7:0] pri);
        rqs_pkg::in_item_t it;
        it               = '0;
        it.cmd           = rqs_pkg::CMD_ENQ;
        it.proc_id       = id;
        it.job_length    = len;
        it.proc_priority = pri;
        send_item(it);
    endtask

    task automatic tick(input logic cont, input logic [15:0] rem);
        rqs_pkg::in_item_t it;
        it               = '0;
        it.cmd           = rqs_pkg::CMD_SCHED;
        it.cur_continues = cont;
        it.cur_remaining = rem;
        send_item(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic set_policy(input logic [2:0] p);
        cfg_valid <= 1'b1;
        cfg_wdata <= p;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cur_policy  = p;
    endtask

    function automatic logic [15:0] work_ticks();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 16'($urandom_range(0, 15));
        if (pick < 85) return 16'($urandom_range(0, 65535));
        if (pick < 92) return 16'h0000;
        return 16'hFFFF;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_fifo_extremes();
        tick(1'b1, 16'd7);                   // continue flag with nothing running
        enqueue(8'hFF, 16'hFFFF, 8'hFF);
        enqueue(8'h00, 16'h0000, 8'h00);
        tick(1'b0, 16'd0);
        tick(1'b1, 16'hFFFF);
        settle();
    endtask

    task automatic test_srtf_preempt();
        set_policy(rqs_pkg::POL_SRTF);
        tick(1'b1, 16'd0);                   // equal length keeps the running entry
        tick(1'b1, 16'd1);
        settle();
    endtask

    task automatic test_round_robin();
        set_policy(rqs_pkg::POL_RR);
        tick(1'b1, 16'd5);
        tick(1'b0, 16'd0);
        tick(1'b0, 16'd0);                   // empty queue, goes idle
        settle();
    endtask

    task automatic test_priority_ties();
        set_policy(rqs_pkg::POL_PRIO);
        enqueue(8'd1, 16'd4, 8'd7);
        enqueue(8'd2, 16'd1, 8'd9);
        enqueue(8'd3, 16'd4, 8'd9);
        tick(1'b0, 16'd0);
        settle();
        set_policy(rqs_pkg::POL_SJF);
        tick(1'b0, 16'd0);                   // equal lengths, oldest wins
        settle();
    endtask

    task automatic test_queue_full();
        int i;
        for (i = 0; i < QDEPTH; i++)
            enqueue(8'(8'h10 + i), 16'(i), 8'(i));
        tick(1'b1, 16'd3);
        settle();
    endtask

    task automatic test_random_policies();
        logic [2:0]        plan [13];
        rqs_pkg::in_item_t it;
        int                ph;
        int                n;
        int                enq_pct;
        plan = '{3'(rqs_pkg::POL_SJF), 3'(rqs_pkg::POL_SRTF), 3'(rqs_pkg::POL_RR),
                 3'(rqs_pkg::POL_PRIO), 3'(rqs_pkg::POL_FIFO), 3'd5,
                 3'(rqs_pkg::POL_SRTF), 3'(rqs_pkg::POL_RR), 3'd6,
                 3'(rqs_pkg::POL_PRIO), 3'(rqs_pkg::POL_SJF), 3'd7,
                 3'(rqs_pkg::POL_SRTF)};
        enq_pct = 50;
        for (ph = 0; ph < 13; ph++) begin
            set_policy(plan[ph]);
            quiet = (ph == 6);
            for (n = 0; n < 104; n++) begin
                // pick fill, mixed or drain bursts at random so the queue swings empty to full
                if (n % 16 == 0) begin
                    case ($urandom_range(0, 2))
                        0: enq_pct = 80;
                        1: enq_pct = 50;
                        default: enq_pct = 20;
                    endcase
                end
                it.cmd           = ($urandom_range(0, 99) < enq_pct) ? rqs_pkg::CMD_ENQ
                                                                     : rqs_pkg::CMD_SCHED;
                it.proc_id       = 8'($urandom_range(0, 255));
                it.job_length    = work_ticks();
                it.proc_priority = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 7))
                                                                : 8'($urandom_range(0, 255));
                it.cur_continues = ($urandom_range(0, 99) < 70);
                it.cur_remaining = work_ticks();
                send_item(it);
            end
            settle();
            quiet = 1'b0;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        m_ready   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_wdata <= rqs_pkg::POL_FIFO;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_fifo_extremes();
        test_srtf_preempt();
        test_round_robin();
        test_priority_ties();
        test_queue_full();
        test_random_policies();

        settle();
        repeat (2 * QDEPTH + 16) @(posedge aclk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
